### design/ssp_pkg.sv
// Package for the seeded shuffle permutation block.
// Holds the request and response payload types, field widths and operation codes.
// No dependencies; imported by the top level.
package ssp_pkg;

  localparam int unsigned ACT_W      = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned SEED_WORDS = 16;
  localparam int unsigned IDX_W      = 13;
  localparam int unsigned VAL_W      = 13;
  localparam int unsigned LEN_W      = 14;

  // Depth of the permutation and inverse tables; the index and value fields match it.
  localparam int unsigned MAX_N      = 8192;

  localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RUN  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ = 2'd2;

  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SLOT_W-1:0] seed_slot;
    logic [SEED_W-1:0] seed_word;
    logic [IDX_W-1:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] perm_value;
    logic [VAL_W-1:0] inverse_value;
    logic             status;
  } rsp_t;

endpackage

### design/ssp_ram.sv
// Simple dual-port RAM: one write port and one registered read port.
// Used for the permutation and inverse tables; no package dependency.
module ssp_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned WIDTH = 13,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/ssp_modulo.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Shared by every swap step of a shuffle run; no package dependency.
module ssp_modulo #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVS_W-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DVD_W);

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // Bring down the next dividend bit and subtract the divisor when it fits.
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    dvd_d    = dvd_q;
    dvs_d    = dvs_q;
    rem_d    = rem_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      dvd_d    = dividend_i;
      dvs_d    = divisor_i;
      rem_d    = '0;
    end else if (active_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DVD_W - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  // A finished remainder is always below the divisor it was taken against.
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("remainder not below divisor");

endmodule

### design/seeded_shuffle_permutation.sv
// Top level of the seeded shuffle permutation block: sequencer, seed store and tables.
// Depends on ssp_pkg, ssp_ram (permutation and inverse tables) and ssp_modulo.
//
//   channel        | ports                          | handshake
//   ---------------+--------------------------------+--------------------------------
//   request        | start, busy, req_i             | taken when start=1 and busy=0
//   configuration  | cfg_we_i, cfg_wdata_i          | written when cfg_we_i=1
//   response       | rsp_valid_o, rsp_o             | one-cycle strobe, no back-pressure
//
// A seed load, or a request with the unused action code, answers in the cycle after
// it is taken. A read in range passes through state S_RDOUT, which takes the registered
// table data, and then the response register; a read out of range answers in the cycle
// after it is taken. A shuffle run keeps busy high through the identity fill, the swaps
// (none when n is below two) and the inverse build, and answers in the same cycle in which
// busy falls; each swap uses the remainder unit, then two table reads and two writes.
// Reset clears the seed store, the run length and the sequencer;
// the tables are not cleared because a read is range-checked against the last run.
// The receiver cannot stall responses, so none are ever held back.
module seeded_shuffle_permutation (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ssp_pkg::req_t                  req_i,
  input  logic                           cfg_we_i,
  input  logic [ssp_pkg::LEN_W-1:0]      cfg_wdata_i,
  output logic                           rsp_valid_o,
  output ssp_pkg::rsp_t                  rsp_o
);

  import ssp_pkg::*;

  // Table address width and the width of an element count (which can equal MAX_N).
  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned NW = $clog2(MAX_N + 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FILL     = 4'd1;
  localparam logic [3:0] S_DIV_GO   = 4'd2;
  localparam logic [3:0] S_DIV_WAIT = 4'd3;
  localparam logic [3:0] S_RD_J     = 4'd4;
  localparam logic [3:0] S_RD_T     = 4'd5;
  localparam logic [3:0] S_WR_J     = 4'd6;
  localparam logic [3:0] S_WR_T     = 4'd7;
  localparam logic [3:0] S_INV      = 4'd8;
  localparam logic [3:0] S_RDOUT    = 4'd9;

  logic [3:0]        state_q, state_d;
  logic [LEN_W-1:0]  len_q;
  logic [SEED_W-1:0] seed_q [SEED_WORDS];
  logic              seed_we;
  logic [NW-1:0]     run_len_q, run_len_d;
  logic [NW-1:0]     n_q, n_d;
  logic [NW-1:0]     k_q, k_d;
  logic [AW-1:0]     top_q, top_d;
  logic [AW-1:0]     j_q, j_d;
  logic [AW-1:0]     tmp_q, tmp_d;
  logic [3:0]        w_q, w_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_idx_q, pend_idx_d;
  logic              rsp_valid_q, rsp_valid_d;
  rsp_t              rsp_q, rsp_d;

  logic [NW-1:0]     eff_n;
  logic              idx_ok;

  logic              perm_we;
  logic [AW-1:0]     perm_waddr;
  logic [AW-1:0]     perm_wdata;
  logic [AW-1:0]     perm_raddr;
  logic [AW-1:0]     perm_rdata;
  logic              inv_we;
  logic [AW-1:0]     inv_rdata;

  logic              div_start;
  logic [NW-1:0]     div_divisor;
  logic              div_done;
  logic [NW-1:0]     div_rem;

  // The configured length saturates at the table depth.
  assign eff_n  = (32'(len_q) > MAX_N) ? NW'(MAX_N) : NW'(len_q);
  // A read is valid only below the length used by the last completed run.
  assign idx_ok = (32'(req_i.entry_index) < 32'(run_len_q));

  assign div_divisor = NW'(top_q) + NW'(1);

  always_comb begin
    state_d     = state_q;
    run_len_d   = run_len_q;
    n_d         = n_q;
    k_d         = k_q;
    top_d       = top_q;
    j_d         = j_q;
    tmp_d       = tmp_q;
    w_d         = w_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    seed_we     = 1'b0;
    perm_we     = 1'b0;
    perm_waddr  = AW'(k_q);
    perm_wdata  = AW'(k_q);
    perm_raddr  = AW'(req_i.entry_index);
    inv_we      = 1'b0;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (req_i.action)
            ACT_LOAD: begin
              seed_we     = 1'b1;
              rsp_valid_d = 1'b1;
              rsp_d       = '0;
            end
            ACT_RUN: begin
              n_d     = eff_n;
              k_d     = '0;
              state_d = S_FILL;
            end
            ACT_READ: begin
              if (idx_ok) begin
                // Both tables are read at the index now; data is there next cycle.
                state_d = S_RDOUT;
              end else begin
                rsp_valid_d  = 1'b1;
                rsp_d        = '0;
                rsp_d.status = ST_RANGE;
              end
            end
            default: begin
              rsp_valid_d = 1'b1;
              rsp_d       = '0;
            end
          endcase
        end
      end

      // Identity fill, one entry per cycle.
      S_FILL: begin
        if (k_q == n_q) begin
          if (n_q >= NW'(2)) begin
            top_d   = AW'(n_q - NW'(1));
            w_d     = '0;
            state_d = S_DIV_GO;
          end else begin
            k_d     = '0;
            pend_d  = 1'b0;
            state_d = S_INV;
          end
        end else begin
          perm_we = 1'b1;
          k_d     = k_q + NW'(1);
        end
      end

      // j = seed[w] mod (top + 1) in the shared remainder unit.
      S_DIV_GO: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_done) begin
          j_d     = div_rem[AW-1:0];
          state_d = S_RD_J;
        end
      end

      S_RD_J: begin
        perm_raddr = j_q;
        state_d    = S_RD_T;
      end

      S_RD_T: begin
        perm_raddr = top_q;
        tmp_d      = perm_rdata;
        state_d    = S_WR_J;
      end

      S_WR_J: begin
        perm_we    = 1'b1;
        perm_waddr = j_q;
        perm_wdata = perm_rdata;
        state_d    = S_WR_T;
      end

      S_WR_T: begin
        perm_we    = 1'b1;
        perm_waddr = top_q;
        perm_wdata = tmp_q;
        w_d        = w_q + 4'd1;
        if (top_q == AW'(1)) begin
          k_d     = '0;
          pend_d  = 1'b0;
          state_d = S_INV;
        end else begin
          top_d   = top_q - AW'(1);
          state_d = S_DIV_GO;
        end
      end

      // Inverse build: read perm[k], then write inverse[perm[k]] = k in the next cycle,
      // overlapped so that one entry completes per cycle.
      S_INV: begin
        inv_we = pend_q;
        if (k_q != n_q) begin
          perm_raddr = AW'(k_q);
          pend_d     = 1'b1;
          pend_idx_d = AW'(k_q);
          k_d        = k_q + NW'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            run_len_d   = n_q;
            rsp_valid_d = 1'b1;
            rsp_d       = '0;
            state_d     = S_IDLE;
          end
        end
      end

      S_RDOUT: begin
        rsp_valid_d         = 1'b1;
        rsp_d.perm_value    = VAL_W'(perm_rdata);
        rsp_d.inverse_value = VAL_W'(inv_rdata);
        rsp_d.status        = ST_OK;
        state_d             = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LEN_W'(MAX_N);
      run_len_q   <= '0;
      pend_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      for (int s = 0; s < SEED_WORDS; s++) begin
        seed_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      run_len_q   <= run_len_d;
      pend_q      <= pend_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if (seed_we) begin
        seed_q[req_i.seed_slot] <= req_i.seed_word;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    top_q      <= top_d;
    j_q        <= j_d;
    tmp_q      <= tmp_d;
    w_q        <= w_d;
    pend_idx_q <= pend_idx_d;
    rsp_q      <= rsp_d;
  end

  ssp_modulo #(
    .DVD_W (SEED_W),
    .DVS_W (NW)
  ) u_modulo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (seed_q[w_q]),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  ssp_ram #(
    .DEPTH (MAX_N),
    .WIDTH (AW)
  ) u_perm_ram (
    .clk_i   (clk_i),
    .we_i    (perm_we),
    .waddr_i (perm_waddr),
    .wdata_i (perm_wdata),
    .raddr_i (perm_raddr),
    .rdata_o (perm_rdata)
  );

  // The inverse table is written at the permutation value just read.
  ssp_ram #(
    .DEPTH (MAX_N),
    .WIDTH (AW)
  ) u_inv_ram (
    .clk_i   (clk_i),
    .we_i    (inv_we),
    .waddr_i (perm_rdata),
    .wdata_i (pend_idx_q),
    .raddr_i (AW'(req_i.entry_index)),
    .rdata_o (inv_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // Every taken request either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || rsp_valid_o))
    else $error("taken request neither answered nor in progress");

  // A range error carries zero table values.
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_RANGE) |->
      (rsp_o.perm_value == '0 && rsp_o.inverse_value == '0))
    else $error("range error with nonzero values");

  // The swap partner never lies above the current top position.
  a_swap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WR_J) |-> (j_q <= top_q))
    else $error("swap index above top");

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV_WAIT))
    else $error("remainder finished outside its wait state");

endmodule
